>>> hw/rtl/pedigree_kinship_table_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pedigree kinship table
// Shared wrappers for concurrent checks, clocked on rising edge.
// ---------------------------------------------------------------------------
`ifndef PEDIGREE_KINSHIP_TABLE_TOP_DEFINES_SVH
`define PEDIGREE_KINSHIP_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define PKT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PKT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pkt_pkg.sv
// ---------------------------------------------------------------------------
// pkt_pkg
// Types and constants shared by the kinship table modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package pkt_pkg;

   localparam int IDX_W       = 9;
   localparam int VAL_W       = 32;
   localparam int FRAC_BITS   = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [VAL_W-1:0] HALF_VALUE = VAL_W'(64'd1 << (FRAC_BITS - 1));

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_PARENT     = 2'd2;
   localparam logic [1:0] ST_NOT_LOADED = 2'd3;

   typedef struct packed {
      logic [1:0]       action;
      logic [IDX_W-1:0] sire;
      logic [IDX_W-1:0] dam;
      logic [IDX_W-1:0] first_member;
      logic [IDX_W-1:0] second_member;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] assigned_index;
      logic [VAL_W-1:0] kinship_value;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_CLEAR,
      OP_NONE
   } op_type;

   // classified transaction passed from front to back
   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] y;
   } entry_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DECODE,
      BK_RD_S,
      BK_RD_D,
      BK_WR,
      BK_DIAG_RD,
      BK_DIAG_WR,
      BK_Q_DONE,
      BK_OUT
   } back_state_type;

endpackage

>>> hw/rtl/pkt_front.sv
// ---------------------------------------------------------------------------
// pkt_front
// Accepts request transactions and classifies them into queue entries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pkt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pkt_pkg::req_type req_data,
   output logic             push,
   output pkt_pkg::entry_type push_entry,
   input  logic             q_full
);
   import pkt_pkg::*;

   logic      slot_valid_ff, slot_valid_in;
   entry_type slot_ff, slot_in;
   logic      take;

   assign push       = slot_valid_ff && !q_full;
   assign push_entry = slot_ff;
   assign req_stall  = slot_valid_ff && q_full;
   assign take       = req_valid && !req_stall;

   always_comb begin
      slot_valid_in = take ? 1'b1 : (push ? 1'b0 : slot_valid_ff);
      slot_in       = slot_ff;
      if (take) begin
         unique case (req_data.action)
            ACT_LOAD: begin
               slot_in = '{op: OP_LOAD, x: req_data.sire, y: req_data.dam};
            end
            ACT_QUERY: begin
               slot_in = '{op: OP_QUERY, x: req_data.first_member,
                           y: req_data.second_member};
            end
            ACT_CLEAR: begin
               slot_in = '{op: OP_CLEAR, x: '0, y: '0};
            end
            default: begin
               slot_in = '{op: OP_NONE, x: '0, y: '0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

endmodule

>>> hw/rtl/pkt_queue.sv
// ---------------------------------------------------------------------------
// pkt_queue
// Short FIFO of classified transactions between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pkt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pkt_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               q_valid,
   output logic               q_full,
   output pkt_pkg::entry_type q_entry,
   output logic [$clog2(pkt_pkg::QUEUE_DEPTH+1)-1:0] q_count
);
   import pkt_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == CW'(QUEUE_DEPTH);
   assign q_entry = slots_ff[rd_ptr_ff];
   assign q_count = count_ff;
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/pkt_back.sv
// ---------------------------------------------------------------------------
// pkt_back
// Executes queued transactions against the triangular kinship memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pkt_back #(
   parameter int MAX_INDIVIDUALS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  pkt_pkg::entry_type q_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pkt_pkg::rsp_type   rsp_data,
   output logic [pkt_pkg::IDX_W-1:0] loaded_count
);
   import pkt_pkg::*;

   localparam int DEPTH = MAX_INDIVIDUALS * (MAX_INDIVIDUALS + 1) / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = (MAX_INDIVIDUALS > 2) ? $clog2(MAX_INDIVIDUALS) : 1;
   localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_INDIVIDUALS);

   // lower-triangle position of one-based pair (a, b)
   function automatic logic [AW-1:0] tri_pos(input logic [IDX_W-1:0] a,
                                             input logic [IDX_W-1:0] b);
      logic [IW-1:0]     hm, lm;
      logic [2*IW:0]     prod;
      hm   = (a > b) ? IW'(a - 1'b1) : IW'(b - 1'b1);
      lm   = (a > b) ? IW'(b - 1'b1) : IW'(a - 1'b1);
      prod = (2*IW+1)'(hm) * (2*IW+1)'({1'b0, hm} + 1'b1);
      return AW'((prod >> 1) + (2*IW+1)'(lm));
   endfunction

   back_state_type   state_ff, state_in;
   op_type           op_ff, op_in;
   logic [IDX_W-1:0] x_ff, x_in, y_ff, y_in, j_ff, j_in, n_ff, n_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [1:0]       stat_ff, stat_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   rsp_type          res_ff, res_in, rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rdata_ff;
   logic [IDX_W-1:0] pa, pb;
   logic [AW-1:0]    addr;
   logic             mem_we;
   logic [VAL_W-1:0] wdata;
   logic             out_free;
   logic [VAL_W-1:0] dam_val;
   logic [VAL_W:0]   pair_sum;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign loaded_count = count_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign addr         = tri_pos(pa, pb);
   assign dam_val      = (y_ff != '0) ? rdata_ff : VAL_W'(0);
   assign pair_sum     = {1'b0, acc_ff} + {1'b0, dam_val};

   always_comb begin
      unique case (state_ff)
         BK_RD_S:    begin pa = j_ff; pb = x_ff; end
         BK_RD_D:    begin pa = j_ff; pb = y_ff; end
         BK_WR:      begin pa = j_ff; pb = n_ff; end
         BK_DIAG_WR: begin pa = n_ff; pb = n_ff; end
         default:    begin pa = x_ff; pb = y_ff; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      stat_in      = stat_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      pop          = 1'b0;
      mem_we       = 1'b0;
      wdata        = VAL_W'(pair_sum >> 1);
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               op_in    = q_entry.op;
               x_in     = q_entry.x;
               y_in     = q_entry.y;
               state_in = BK_DECODE;
            end
         end
         BK_DECODE: begin
            res_in   = '{assigned_index: '0, kinship_value: '0, status: ST_OK};
            state_in = BK_OUT;
            unique case (op_ff)
               OP_LOAD: begin
                  if (count_ff >= MAX_N) begin
                     res_in.status = ST_FULL;
                  end else begin
                     stat_in = ST_OK;
                     if (x_ff > count_ff) begin
                        x_in    = '0;
                        stat_in = ST_PARENT;
                     end
                     if (y_ff > count_ff) begin
                        y_in    = '0;
                        stat_in = ST_PARENT;
                     end
                     n_in     = count_ff + 1'b1;
                     j_in     = IDX_W'(1);
                     state_in = (count_ff == '0) ? BK_DIAG_RD : BK_RD_S;
                  end
               end
               OP_QUERY: begin
                  if (x_ff == '0 || y_ff == '0 || x_ff > count_ff || y_ff > count_ff) begin
                     res_in.status = ST_NOT_LOADED;
                  end else begin
                     state_in = BK_Q_DONE;   // read of (x, y) issued this cycle
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         BK_RD_S: begin
            state_in = BK_RD_D;
         end
         BK_RD_D: begin
            acc_in   = (x_ff != '0) ? rdata_ff : '0;
            state_in = BK_WR;
         end
         BK_WR: begin
            mem_we   = 1'b1;
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == n_ff) ? BK_DIAG_RD : BK_RD_S;
         end
         BK_DIAG_RD: begin
            state_in = BK_DIAG_WR;
         end
         BK_DIAG_WR: begin
            mem_we   = 1'b1;
            wdata    = HALF_VALUE + ((x_ff != '0 && y_ff != '0) ? (rdata_ff >> 1) : '0);
            count_in = n_ff;
            res_in   = '{assigned_index: n_ff, kinship_value: wdata, status: stat_ff};
            state_in = BK_OUT;
         end
         BK_Q_DONE: begin
            res_in   = '{assigned_index: '0, kinship_value: rdata_ff, status: ST_OK};
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      stat_ff <= stat_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

>>> hw/rtl/pedigree_kinship_table_top.sv
// ---------------------------------------------------------------------------
// pedigree_kinship_table_top
// Tabular-method kinship table: load pedigree records, query pairs, clear.
// ---------------------------------------------------------------------------
// Channel  Direction  Payload            Handshake
// req_     in         pkt_pkg::req_type  req_valid / req_stall
// rsp_     out        pkt_pkg::rsp_type  rsp_valid / rsp_stall
//
// A load of individual n makes two reads and one write on the single kinship
// memory port per earlier individual, then a diagonal read and write. A hit
// query passes DECODE, Q_DONE and OUT; a miss, a clear, an unused action or a
// full-table load passes DECODE and OUT. OUT loads the response register.
// Reset clears the loaded count and all control; memory contents are unknown
// until written, and no row is readable before its load writes it.
// A front slot and a 2-entry queue keep accepting while the back end works;
// the output register frees the back end while a response sits stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pedigree_kinship_table_top_defines.svh"
module pedigree_kinship_table_top #(
   parameter int MAX_INDIVIDUALS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pkt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pkt_pkg::rsp_type rsp_data
);
   import pkt_pkg::*;

   logic                push, pop, q_valid, q_full;
   entry_type           push_entry, q_entry;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic [IDX_W-1:0]    loaded_count;

   // front: take and classify transactions
   pkt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   // decoupling queue
   pkt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_entry    (q_entry),
      .q_count    (q_count)
   );

   // back: table fill, lookups, response register
   pkt_back #(
      .MAX_INDIVIDUALS (MAX_INDIVIDUALS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .loaded_count (loaded_count)
   );

   // a failed query or full table never reports a value or index
   `PKT_ASSERT_NOW(a_fail_zero, clock, reset,
      rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_NOT_LOADED),
      rsp_data.assigned_index == '0 && rsp_data.kinship_value == '0,
      "failed transaction carries data")
   // loaded count never exceeds table size
   `PKT_ASSERT_NOW(a_count_max, clock, reset, 1'b1,
      loaded_count <= IDX_W'(MAX_INDIVIDUALS), "loaded count beyond table size")
   // a successful load response carries the current count as its index
   `PKT_ASSERT_NOW(a_load_index, clock, reset,
      rsp_valid && rsp_data.assigned_index != '0 && !$stable(rsp_valid),
      rsp_data.assigned_index == loaded_count, "assigned index differs from count")
   // queue never overfills
   `PKT_ASSERT_NEXT(a_queue_bound, clock, reset, q_full && !pop,
      q_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue count moved while full")

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Kinship table testbench: a directed table of loads, queries and clears,
// then random pedigrees; each response is checked against a local
// tabular-method kinship predictor with random idle on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
   import pkt_pkg::*;

   localparam int MAX_IND   = 256;
   localparam int N_RANDOM  = 800;
   localparam int LIMIT_CYC = 3000000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   pedigree_kinship_table_top #(.MAX_INDIVIDUALS(MAX_IND)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // predictor state: full square table, only rows 1..kin_count are reachable
   logic [VAL_W-1:0] kin_table [1:MAX_IND][1:MAX_IND];
   int               kin_count;
   rsp_type          kin_expected [$];
   int               fail_count;
   int               cycle_count = 0;
   logic             hold_off;   // long receiver hold-off to fill the block
   logic             no_idle;    // stretch with no idling on either side

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp);
      $display("mismatch %s: got %0h expected %0h at cycle %0d",
               what, got, exp, cycle_count);
      fail_count++;
   endtask

   function automatic logic [VAL_W-1:0] kin_get(input int a, input int b);
      if (a == 0 || b == 0) return '0;
      return kin_table[a][b];
   endfunction

   // tabular method, one transaction in, one response out
   function automatic rsp_type kin_predict(input req_type r);
      rsp_type o;
      int s, d, n;
      logic [VAL_W:0] sum;
      o = '0;
      case (r.action)
         ACT_LOAD: begin
            if (kin_count >= MAX_IND) begin
               o.status = ST_FULL;
            end else begin
               s = int'(r.sire); d = int'(r.dam); n = kin_count + 1;
               if (s > kin_count) begin s = 0; o.status = ST_PARENT; end
               if (d > kin_count) begin d = 0; o.status = ST_PARENT; end
               for (int j = 1; j < n; j++) begin
                  sum = kin_get(j, s) + kin_get(j, d);
                  kin_table[j][n] = sum[VAL_W:1];
                  kin_table[n][j] = sum[VAL_W:1];
               end
               o.kinship_value = HALF_VALUE + (kin_get(s, d) >> 1);
               kin_table[n][n] = o.kinship_value;
               kin_count = n;
               o.assigned_index = n[IDX_W-1:0];
            end
         end
         ACT_QUERY: begin
            if (r.first_member == 0 || r.second_member == 0 ||
                r.first_member > kin_count || r.second_member > kin_count)
               o.status = ST_NOT_LOADED;
            else
               o.kinship_value = kin_table[r.first_member][r.second_member];
         end
         ACT_CLEAR: kin_count = 0;
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type mk_req(input logic [1:0] a, input int s, input int d,
                                      input int f, input int m);
      req_type r;
      r.action = a; r.sire = IDX_W'(s); r.dam = IDX_W'(d);
      r.first_member = IDX_W'(f); r.second_member = IDX_W'(m);
      return r;
   endfunction

   // send one transaction; optional typed-in expectation is checked against
   // the predictor so the table itself is verified too. Valid stays high
   // from one transaction to the next unless an idle cycle drops it.
   task automatic send_req(input req_type r, input bit has_exp, input rsp_type e);
      rsp_type p;
      bit      idle;
      idle = !no_idle && ($urandom_range(99) < 34);
      if (idle) req_valid <= 1'b0;
      while (idle) begin
         @(posedge clock);
         idle = !no_idle && ($urandom_range(99) < 34);
      end
      p = kin_predict(r);
      if (has_exp && p !== e) report_mismatch("directed row", p, e);
      kin_expected.push_back(p);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: random stall, plus the long hold-off when asked
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= hold_off || (!no_idle && $urandom_range(99) < 34);
   end

   // response checker, sampled at the edge
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (kin_expected.size() == 0) begin
            report_mismatch("unexpected response", rsp_data, 0);
         end else begin
            e = kin_expected.pop_front();
            if (rsp_data.assigned_index !== e.assigned_index)
               report_mismatch("assigned_index", rsp_data.assigned_index,
                               e.assigned_index);
            if (rsp_data.kinship_value !== e.kinship_value)
               report_mismatch("kinship_value", rsp_data.kinship_value,
                               e.kinship_value);
            if (rsp_data.status !== e.status)
               report_mismatch("status", rsp_data.status, e.status);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYC) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[pedigree_kinship_table_top] ERROR");
         $finish;
      end
   end

   // directed stimulus table
   typedef struct {
      req_type r;
      bit      has_exp;
      rsp_type e;
   } dir_row_type;

   function automatic rsp_type mk_rsp(input int idx, input logic [VAL_W-1:0] v,
                                      input logic [1:0] st);
      rsp_type o;
      o.assigned_index = IDX_W'(idx); o.kinship_value = v; o.status = st;
      return o;
   endfunction

   localparam logic [VAL_W-1:0] ONE_VAL = HALF_VALUE << 1;

   dir_row_type dir_rows [$];

   task automatic add_row(input req_type r, input bit h, input rsp_type e);
      dir_row_type row;
      row.r = r; row.has_exp = h; row.e = e;
      dir_rows.push_back(row);
   endtask

   // random pedigree transaction: mostly well-formed loads and in-range queries
   function automatic req_type rand_req();
      req_type r;
      int k;
      r = mk_req(ACT_LOAD, $urandom_range(511), $urandom_range(511),
                 $urandom_range(511), $urandom_range(511));
      k = $urandom_range(99);
      if (k < 55) begin
         r.action = ACT_LOAD;
         if (kin_count > 0 && $urandom_range(9) < 8) begin
            r.sire = IDX_W'($urandom_range(kin_count, 0));
            r.dam  = IDX_W'($urandom_range(kin_count, 0));
         end
      end else if (k < 92) begin
         r.action = ACT_QUERY;
         if (kin_count > 0 && $urandom_range(9) < 8) begin
            r.first_member  = IDX_W'($urandom_range(kin_count, 1));
            r.second_member = IDX_W'($urandom_range(kin_count, 1));
         end
      end else if (k < 97) begin
         r.action = ACT_CLEAR;
      end else begin
         r.action = ACT_UNUSED;
      end
      return r;
   endfunction

   initial begin
      int      n;
      rsp_type z;
      z = '0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      fail_count = 0;
      hold_off = 1'b0; no_idle = 1'b0; kin_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: nothing loaded, queries miss, unused code does nothing
      add_row(mk_req(ACT_QUERY, 0, 0, 1, 1), 1, mk_rsp(0, 0, ST_NOT_LOADED));
      add_row(mk_req(ACT_UNUSED, 511, 511, 511, 511), 1, z);
      add_row(mk_req(ACT_LOAD, 0, 0, 0, 0), 1, mk_rsp(1, HALF_VALUE, ST_OK));
      add_row(mk_req(ACT_LOAD, 0, 0, 0, 0), 1, mk_rsp(2, HALF_VALUE, ST_OK));
      // full sibling and inbred offspring
      add_row(mk_req(ACT_LOAD, 1, 2, 0, 0), 1, mk_rsp(3, HALF_VALUE, ST_OK));
      add_row(mk_req(ACT_LOAD, 1, 2, 0, 0), 1, mk_rsp(4, HALF_VALUE, ST_OK));
      add_row(mk_req(ACT_LOAD, 3, 4, 0, 0), 0, z);
      // self-mating reaches the top of the value range
      add_row(mk_req(ACT_LOAD, 5, 5, 0, 0), 0, z);
      add_row(mk_req(ACT_LOAD, 6, 6, 0, 0), 0, z);
      // parent not earlier: own index and the field maximum
      add_row(mk_req(ACT_LOAD, 8, 511, 0, 0), 1, mk_rsp(8, HALF_VALUE, ST_PARENT));
      add_row(mk_req(ACT_LOAD, 1, 256, 0, 0), 1, mk_rsp(9, HALF_VALUE, ST_PARENT));
      add_row(mk_req(ACT_QUERY, 0, 0, 3, 4), 0, z);
      add_row(mk_req(ACT_QUERY, 0, 0, 7, 7), 0, z);
      add_row(mk_req(ACT_QUERY, 0, 0, 1, 2), 1, mk_rsp(0, 0, ST_OK));
      add_row(mk_req(ACT_QUERY, 511, 511, 0, 3), 1, mk_rsp(0, 0, ST_NOT_LOADED));
      add_row(mk_req(ACT_QUERY, 0, 0, 3, 10), 1, mk_rsp(0, 0, ST_NOT_LOADED));
      add_row(mk_req(ACT_QUERY, 0, 0, 511, 1), 1, mk_rsp(0, 0, ST_NOT_LOADED));
      add_row(mk_req(ACT_CLEAR, 511, 511, 511, 511), 1, z);
      add_row(mk_req(ACT_QUERY, 0, 0, 1, 1), 1, mk_rsp(0, 0, ST_NOT_LOADED));
      foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].has_exp, dir_rows[i].e);

      // fill the table to capacity with short lineages, then overflow once
      for (int i = 0; i < MAX_IND; i++) begin
         n = kin_count;
         send_req(mk_req(ACT_LOAD, n > 0 ? $urandom_range(n) : 0,
                         n > 1 ? n - 1 : 0, 0, 0), 0, z);
      end
      send_req(mk_req(ACT_LOAD, 1, 2, 0, 0), 1, mk_rsp(0, 0, ST_FULL));
      send_req(mk_req(ACT_QUERY, 0, 0, 256, 256), 0, z);
      send_req(mk_req(ACT_QUERY, 0, 0, 1, 256), 0, z);
      send_req(mk_req(ACT_CLEAR, 0, 0, 0, 0), 1, z);

      // long receiver hold-off while the sender keeps offering, in its own process
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_req(rand_req(), 0, z);
      join

      for (int i = 0; i < N_RANDOM; i++) begin
         // keep tables small most of the time to bound load cost
         if (kin_count > 40 && $urandom_range(9) < 3)
            send_req(mk_req(ACT_CLEAR, 0, 0, 0, 0), 1, z);
         no_idle = (i >= 400 && i < 550);
         send_req(rand_req(), 0, z);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (kin_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("[pedigree_kinship_table_top] OK");
      else
         $display("[pedigree_kinship_table_top] ERROR");
      $finish;
   end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pkt_pkg.sv
hw/rtl/pkt_front.sv
hw/rtl/pkt_queue.sv
hw/rtl/pkt_back.sv
hw/rtl/pedigree_kinship_table_top.sv
dv/tb_top.sv
